FILE: design/ctcb_pkg.sv
// Shared types and codes for the tiled COO-to-CSR builder.
// No dependencies.
package ctcb_pkg;

  localparam logic [1:0] OP_COUNT    = 2'd0;
  localparam logic [1:0] OP_FINALIZE = 2'd1;
  localparam logic [1:0] OP_FILL     = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_PLACE = 2'd1;
  localparam logic [1:0] KIND_CAP   = 2'd2;
  localparam logic [1:0] KIND_PTR   = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_CAP   = 2'd2;
  localparam logic [1:0] ERR_SAT   = 2'd3;

  localparam logic [1:0] MODE_GENERAL = 2'd0;
  localparam logic [1:0] MODE_SKEW    = 2'd2;

  localparam logic [2:0] CFG_NUM_ROWS  = 3'd0;
  localparam logic [2:0] CFG_NUM_COLS  = 3'd1;
  localparam logic [2:0] CFG_STRIPE    = 3'd2;
  localparam logic [2:0] CFG_ALIGN     = 3'd3;
  localparam logic [2:0] CFG_SYM_MODE  = 3'd4;
  localparam logic [2:0] CFG_MIRROR_EN = 3'd5;

  // divider width: covers num_rows + ROWS_PER_TILE - 1
  localparam int DW = 21;

  typedef struct packed {
    logic [1:0]  op;
    logic [19:0] row;
    logic [19:0] col;
    logic [63:0] val;
    logic [3:0]  qtile;
    logic [6:0]  qrow;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  tile_id;
    logic [15:0] slot;
    logic [19:0] local_col;
    logic [63:0] value_bits;
    logic [1:0]  error_code;
    logic        last;
  } res_t;

endpackage

FILE: design/ctcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ctcb_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                           wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                           rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/ctcb_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses ctcb_pkg for nothing; self-contained.
module ctcb_div #(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  q;
  logic [W:0]    r;
  logic [W-1:0]  d;
  logic          busy;
  logic [W:0]    rs;

  assign rs  = {r[W-1:0], q[W-1]};
  assign quo = q;
  assign rem = r[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        q    <= num;
        r    <= '0;
        d    <= den;
      end else if (busy) begin
        if (rs >= {1'b0, d}) begin
          r <= rs - {1'b0, d};
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= rs;
          q <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/ctcb_queue.sv
// Short command queue between front and back.
// Depends on ctcb_pkg (cmd_t).
module ctcb_queue
  import ctcb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_data
);

  localparam int AW = $clog2(DEPTH);

  cmd_t          ent [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt == (AW + 1)'(DEPTH));
  assign q_valid = (cnt != '0);
  assign q_data  = ent[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

endmodule

FILE: design/ctcb_front.sv
// Front end: takes input beats and splits count/fill entries into
// the entry and, when mirroring applies, its mirror. Depends on ctcb_pkg.
module ctcb_front
  import ctcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [19:0] row_coord,
  input  logic [19:0] col_coord,
  input  logic [63:0] entry_bits,
  input  logic [3:0]  query_tile,
  input  logic [6:0]  query_row,
  input  logic [1:0]  sym_mode,
  input  logic        mirror_en,
  output logic        push,
  output cmd_t        push_data,
  input  logic        q_full
);

  logic        have;
  logic        step;
  cmd_t        item;
  logic        mir_need;

  assign in_ready = !have && enable;
  assign mir_need = (item.op == OP_COUNT || item.op == OP_FILL) &&
                    sym_mode != MODE_GENERAL && mirror_en && item.row != item.col;
  assign push     = have && !q_full;

  always_comb begin
    push_data = item;
    if (step) begin
      push_data.row  = item.col;
      push_data.col  = item.row;
      push_data.val  = (sym_mode == MODE_SKEW) ? {~item.val[63], item.val[62:0]} : item.val;
      push_data.last = 1'b1;
    end else begin
      push_data.last = !mir_need;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op    <= opcode;
      item.row   <= row_coord;
      item.col   <= col_coord;
      item.val   <= entry_bits;
      item.qtile <= query_tile;
      item.qrow  <= query_row;
      item.last  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      step <= 1'b0;
    end else if (in_valid && in_ready) begin
      have <= 1'b1;
      step <= 1'b0;
    end else if (push) begin
      if (!step && mir_need) begin
        step <= 1'b1;
      end else begin
        have <= 1'b0;
      end
    end
  end

endmodule

FILE: design/ctcb_back.sv
// Back end: tile mapping, counter and cursor updates, finalize sweep,
// row pointer reads, output register. Depends on ctcb_pkg, ctcb_div, ctcb_ram.
module ctcb_back
  import ctcb_pkg::*;
#(
  parameter int ROWS_PER_TILE = 64,
  parameter int TILES         = 16,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [19:0] num_rows,
  input  logic [19:0] num_cols,
  input  logic [19:0] stripe_width,
  input  logic [12:0] align_unit,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        pop,
  output logic        clear_done,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        res
);

  localparam int DEPTH  = TILES * ROWS_PER_TILE;
  localparam int IDX_W  = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int TILE_W = TILES > 1 ? $clog2(TILES) : 1;
  localparam int ROW_W  = ROWS_PER_TILE > 1 ? $clog2(ROWS_PER_TILE) : 1;
  // ROWS_PER_TILE must be a power of two (the block does not enforce it): row block is a shift, local row a mask
  localparam int SH     = $clog2(ROWS_PER_TILE);
  localparam int CW     = COUNT_WIDTH;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_FR   = 4'd7;
  localparam logic [3:0] S_FW   = 4'd8;
  localparam logic [3:0] S_FCAP = 4'd9;
  localparam logic [3:0] S_FDIV = 4'd10;
  localparam logic [3:0] S_FMUL = 4'd11;
  localparam logic [3:0] S_FOUT = 4'd12;
  localparam logic [3:0] S_QRD  = 4'd13;

  logic [3:0]        state;
  cmd_t              cmd_q;
  logic              fin;
  logic [15:0]       capacity;
  logic [CW-1:0]     totals [TILES];
  logic [IDX_W-1:0]  clr_addr;
  logic [TILE_W-1:0] ptr_tile;
  logic [ROW_W-1:0]  ptr_row;
  logic [CW-1:0]     run;
  logic [15:0]       mx;

  logic [DW-1:0]     stripe;
  logic [19:0]       lcol;
  logic [DW-1:0]     rblk;
  logic [ROW_W-1:0]  rrem;
  logic [DW-1:0]     blocks;
  logic [2*DW-1:0]   sb_prod;
  logic [2*DW:0]     tile_full;
  logic [33:0]       cap_prod;

  logic              div_go;
  logic [DW-1:0]     div_q, div_r;
  logic [DW-1:0]     div_num, div_den;
  logic              div_done;

  logic [19:0]       w_eff, nr_eff, nc_eff;
  logic [12:0]       a_eff;
  logic              rng_ok;
  logic [TILE_W-1:0] cur_tile;
  logic [TILE_W-1:0] qt_idx;
  logic [IDX_W-1:0]  cur_idx;
  logic [IDX_W-1:0]  ptr_idx;
  logic [IDX_W-1:0]  q_idx;
  logic [TILE_W-1:0] tot_idx;
  logic [CW-1:0]     tot_rd;
  logic              qt_bad, qr_bad, qr_top;
  logic              place_bad;

  logic              row_we, cur_we;
  logic [IDX_W-1:0]  row_waddr, raddr;
  logic [CW-1:0]     row_wdata, cur_wdata;
  logic [CW-1:0]     row_rdata, cur_rdata;
  logic [CW-1:0]     base;
  logic [15:0]       mx_in;

  assign w_eff  = (stripe_width == '0) ? 20'd1 : stripe_width;
  assign nr_eff = (num_rows == '0) ? 20'd1 : num_rows;
  assign nc_eff = (num_cols == '0) ? 20'd1 : num_cols;
  assign a_eff  = (align_unit == '0) ? 13'd1 : align_unit;

  assign rng_ok   = cmd_q.row < nr_eff && cmd_q.col < nc_eff;
  assign sb_prod  = stripe * blocks;
  assign cur_tile = tile_full[TILE_W-1:0];
  assign qt_idx   = TILE_W'(8'(cmd_q.qtile));
  assign cur_idx  = IDX_W'(32'(cur_tile) * 32'(ROWS_PER_TILE) + 32'(rrem));
  assign ptr_idx  = IDX_W'(32'(ptr_tile) * 32'(ROWS_PER_TILE) + 32'(ptr_row));
  assign q_idx    = IDX_W'(32'(qt_idx) * 32'(ROWS_PER_TILE) + 32'(cmd_q.qrow));
  assign qt_bad   = {5'd0, cmd_q.qtile} >= 9'(TILES);
  assign qr_bad   = 13'(cmd_q.qrow) > 13'(ROWS_PER_TILE);
  assign qr_top   = 13'(cmd_q.qrow) == 13'(ROWS_PER_TILE);
  assign place_bad = !rng_ok || tile_full >= (2 * DW + 1)'(TILES) ||
                     (cmd_q.op == OP_COUNT && fin) || (cmd_q.op == OP_FILL && !fin);
  assign base     = (ptr_row == '0) ? '0 : run;
  assign mx_in    = (32'(totals[ptr_tile]) > 32'(16'hFFFF)) ? 16'hFFFF
                                                           : 16'(totals[ptr_tile]);

  assign clear_done = (state != S_CLR);
  assign pop        = (state == S_IDLE) && q_valid && !out_valid;
  assign div_go     = (state == S_DISP && (cmd_q.op == OP_COUNT || cmd_q.op == OP_FILL)) ||
                      state == S_FCAP;

  always_comb begin
    case (state)
      S_DISP:  tot_idx = qt_idx;
      S_FW:    tot_idx = ptr_tile;
      default: tot_idx = cur_tile;
    endcase
  end
  assign tot_rd = totals[tot_idx];

  always_comb begin
    case (state)
      S_CHK:   raddr = cur_idx;
      S_FR:    raddr = ptr_idx;
      default: raddr = q_idx;
    endcase
  end

  // one divider: column by stripe width for entries, capacity rounding on finalize
  always_comb begin
    if (state == S_FCAP) begin
      div_num = DW'(mx) + DW'(a_eff) - DW'(1);
      div_den = DW'(a_eff);
    end else begin
      div_num = DW'(cmd_q.col);
      div_den = DW'(w_eff);
    end
  end

  always_comb begin
    row_we    = 1'b0;
    cur_we    = 1'b0;
    row_waddr = cur_idx;
    row_wdata = row_rdata + CW'(1);
    cur_wdata = cur_rdata + CW'(1);
    case (state)
      S_CLR: begin
        row_we    = 1'b1;
        row_waddr = clr_addr;
        row_wdata = '0;
      end
      S_WR: begin
        if (cmd_q.op == OP_COUNT) begin
          row_we = 1'b1;
        end else begin
          cur_we = (cur_rdata != '1);
        end
      end
      S_FW: begin
        row_waddr = ptr_idx;
        row_we    = !fin;
        row_wdata = base;
        cur_we    = 1'b1;
        cur_wdata = fin ? row_rdata : base;
      end
      default: ;
    endcase
  end

  ctcb_ram #(.W(CW), .DEPTH(DEPTH)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(raddr), .rdata(row_rdata)
  );

  ctcb_ram #(.W(CW), .DEPTH(DEPTH)) u_cur_ram (
    .clk(clk), .we(cur_we), .waddr(row_waddr), .wdata(cur_wdata),
    .raddr(raddr), .rdata(cur_rdata)
  );

  ctcb_div #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q), .rem(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      fin       <= 1'b0;
      capacity  <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TILES; i++) begin
        totals[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cmd_q <= q_data;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res.kind       <= KIND_PTR;
          res.tile_id    <= cmd_q.qtile;
          res.slot       <= '0;
          res.local_col  <= '0;
          res.value_bits <= '0;
          res.error_code <= ERR_OK;
          res.last       <= cmd_q.last;
          case (cmd_q.op)
            OP_COUNT, OP_FILL: state <= S_DIV;
            OP_FINALIZE: begin
              ptr_tile <= '0;
              ptr_row  <= '0;
              mx       <= '0;
              state    <= S_FR;
            end
            default: begin
              if (qt_bad || qr_bad) begin
                res.error_code <= ERR_RANGE;
                out_valid      <= 1'b1;
                state          <= S_IDLE;
              end else if (qr_top) begin
                res.slot  <= 16'(tot_rd);
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end else begin
                state <= S_QRD;
              end
            end
          endcase
        end
        S_QRD: begin
          res.slot  <= 16'(row_rdata);
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            stripe <= div_q;
            lcol   <= div_r[19:0];
            rblk   <= DW'(cmd_q.row) >> SH;
            rrem   <= ROW_W'(cmd_q.row & 20'(ROWS_PER_TILE - 1));
            blocks <= (DW'(nr_eff) + DW'(ROWS_PER_TILE - 1)) >> SH;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          tile_full <= (2 * DW + 1)'(sb_prod) + (2 * DW + 1)'(rblk);
          state     <= S_CHK;
        end
        S_CHK: begin
          res.kind       <= (cmd_q.op == OP_COUNT) ? KIND_ACK : KIND_PLACE;
          res.tile_id    <= '0;
          res.slot       <= '0;
          res.local_col  <= '0;
          res.value_bits <= '0;
          res.error_code <= ERR_RANGE;
          res.last       <= cmd_q.last;
          if (place_bad) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (cmd_q.op == OP_COUNT && tot_rd == '1) begin
            res.tile_id    <= 4'(cur_tile);
            res.error_code <= ERR_SAT;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          out_valid      <= 1'b1;
          state          <= S_IDLE;
          res.error_code <= ERR_OK;
          if (cmd_q.op == OP_COUNT) begin
            totals[cur_tile] <= tot_rd + CW'(1);
            res.tile_id      <= 4'(cur_tile);
          end else if (32'(cur_rdata) >= 32'(capacity)) begin
            res.error_code <= ERR_CAP;
          end else begin
            res.tile_id    <= 4'(cur_tile);
            res.slot       <= 16'(cur_rdata);
            res.local_col  <= lcol;
            res.value_bits <= cmd_q.val;
          end
        end
        S_FR: state <= S_FW;
        S_FW: begin
          if (!fin) begin
            run <= base + row_rdata;
          end
          if (ptr_row == '0 && mx_in > mx) begin
            mx <= mx_in;
          end
          state <= S_FR;
          if (32'(ptr_row) == ROWS_PER_TILE - 1) begin
            ptr_row <= '0;
            if (32'(ptr_tile) == TILES - 1) begin
              state <= S_FCAP;
            end else begin
              ptr_tile <= ptr_tile + 1'b1;
            end
          end else begin
            ptr_row <= ptr_row + 1'b1;
          end
        end
        S_FCAP: state <= S_FDIV;
        S_FDIV: begin
          if (div_done) begin
            cap_prod <= 34'(div_q) * 34'(a_eff);
            state    <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (cap_prod == '0) begin
            capacity <= 16'd1;
          end else if (cap_prod > 34'(16'hFFFF)) begin
            capacity <= 16'hFFFF;
          end else begin
            capacity <= cap_prod[15:0];
          end
          state <= S_FOUT;
        end
        S_FOUT: begin
          fin            <= 1'b1;
          res.kind       <= KIND_CAP;
          res.tile_id    <= '0;
          res.slot       <= capacity;
          res.local_col  <= '0;
          res.value_bits <= '0;
          res.error_code <= ERR_OK;
          res.last       <= cmd_q.last;
          out_valid      <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/tiled_coo_to_csr_builder.sv
// Top level of the tiled COO-to-CSR builder: configuration registers,
// front end, command queue and back end. Depends on ctcb_pkg and all ctcb_* modules.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one register
//    per beat; cfg_ready is always high. Write only while the block is idle.
//  - Input channel takes one item per beat: count, finalize, fill or read.
//    Count and fill beats give one or two result beats (entry, then mirror).
//  - Output channel presents one result per beat from an output register.
//  - Placement: a count or fill placement passes through the bit-serial divider that
//    maps the column to a stripe, then the tile multiply and the range check;
//    the row block is a shift. A mirrored placement follows as its own command.
//    A read of the top row answers from the tile totals; other rows wait for a
//    row store read. Finalize walks the row store with a read and a write state
//    per entry, then runs the capacity division on the same divider.
//  - Throughput: the back end runs one placement at a time and waits for its
//    result beat to leave before taking the next one.
//  - Reset: after rst the row store is cleared one entry per cycle, all
//    TILES*ROWS_PER_TILE entries, with in_ready low. Config writes are taken.
//    A new matrix needs a reset.
//  - When the receiver stalls the result waits in the output register; the
//    front keeps taking beats into the command queue until it fills.
module tiled_coo_to_csr_builder
  import ctcb_pkg::*;
#(
  parameter int ROWS_PER_TILE = 64,
  parameter int TILES         = 16,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [19:0] row_coord,
  input  logic [19:0] col_coord,
  input  logic [63:0] entry_bits,
  input  logic [3:0]  query_tile,
  input  logic [6:0]  query_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [3:0]  tile_id,
  output logic [15:0] slot,
  output logic [19:0] local_col,
  output logic [63:0] value_bits,
  output logic [1:0]  error_code,
  output logic        last
);

  logic [19:0] num_rows, num_cols, stripe_width;
  logic [12:0] align_unit;
  logic [1:0]  symmetry_mode;
  logic        mirror_enable;

  logic  push, q_full, pop, q_valid, clear_done;
  cmd_t  push_data, q_data;
  res_t  res;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows      <= 20'd1;
      num_cols      <= 20'd1;
      stripe_width  <= 20'd4096;
      align_unit    <= 13'd64;
      symmetry_mode <= MODE_GENERAL;
      mirror_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_ROWS:  num_rows      <= cfg_data;
        CFG_NUM_COLS:  num_cols      <= cfg_data;
        CFG_STRIPE:    stripe_width  <= cfg_data;
        CFG_ALIGN:     align_unit    <= cfg_data[12:0];
        CFG_SYM_MODE:  symmetry_mode <= cfg_data[1:0];
        CFG_MIRROR_EN: mirror_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: splits beats into placements
  ctcb_front u_front (
    .clk(clk), .rst(rst), .enable(clear_done),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .row_coord(row_coord), .col_coord(col_coord),
    .entry_bits(entry_bits), .query_tile(query_tile), .query_row(query_row),
    .sym_mode(symmetry_mode), .mirror_en(mirror_enable),
    .push(push), .push_data(push_data), .q_full(q_full)
  );

  ctcb_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(pop), .q_valid(q_valid), .q_data(q_data)
  );

  // back: executes one command at a time
  ctcb_back #(
    .ROWS_PER_TILE(ROWS_PER_TILE), .TILES(TILES), .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst),
    .num_rows(num_rows), .num_cols(num_cols), .stripe_width(stripe_width),
    .align_unit(align_unit),
    .q_valid(q_valid), .q_data(q_data), .pop(pop), .clear_done(clear_done),
    .out_valid(out_valid), .out_ready(out_ready), .res(res)
  );

  assign kind       = res.kind;
  assign tile_id    = res.tile_id;
  assign slot       = res.slot;
  assign local_col  = res.local_col;
  assign value_bits = res.value_bits;
  assign error_code = res.error_code;
  assign last       = res.last;

endmodule
